@@ rtl/core/rvopimm_pkg.sv @@
`default_nettype none

package rvopimm_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_ALU   = 2'd0,
        KIND_LUI   = 2'd1,
        KIND_AUIPC = 2'd2,
        KIND_NOP   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        F3_ADD  = 3'd0,
        F3_SLL  = 3'd1,
        F3_SLT  = 3'd2,
        F3_SLTU = 3'd3,
        F3_XOR  = 3'd4,
        F3_SR   = 3'd5,
        F3_OR   = 3'd6,
        F3_AND  = 3'd7
    } funct3_t;

    localparam logic [6:0] F7_SRL = 7'd0;
    localparam logic [6:0] F7_SRA = 7'd32;

    typedef enum logic [3:0] {
        OP_ADD,
        OP_SLL,
        OP_SLT,
        OP_SLTU,
        OP_XOR,
        OP_SRL,
        OP_SRA,
        OP_OR,
        OP_AND,
        OP_UPPER,
        OP_NONE
    } alu_op_t;

    // decoded request passed from front end to back end
    typedef struct packed {
        logic        illegal;
        logic        wr;
        alu_op_t     op;
        logic [4:0]  rd;
        logic [4:0]  rs;
        logic [4:0]  shamt;
        logic [31:0] operand;
    } uop_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

@@ rtl/core/rvopimm_front.sv @@
`default_nettype none

module rvopimm_front #(
    parameter int REG_COUNT = 32
) (
    input  wire logic [1:0]        kind,
    input  wire logic [4:0]        dest_reg,
    input  wire logic [4:0]        src_reg,
    input  wire logic [2:0]        op_code,
    input  wire logic [6:0]        shift_variant,
    input  wire logic [11:0]       short_imm,
    input  wire logic [31:0]       upper_imm,
    input  wire logic [31:0]       pc_value,
    output rvopimm_pkg::uop_t      uop
);

    localparam logic [5:0] RegCountW = 6'(REG_COUNT);

    rvopimm_pkg::kind_t   kind_e;
    rvopimm_pkg::funct3_t f3_e;
    logic [31:0]          imm_sext;
    logic                 rd_ok;

    assign kind_e   = rvopimm_pkg::kind_t'(kind);
    assign f3_e     = rvopimm_pkg::funct3_t'(op_code);
    assign imm_sext = {{20{short_imm[11]}}, short_imm};
    assign rd_ok    = (dest_reg != 5'd0) && ({1'b0, dest_reg} < RegCountW);

    always_comb
    begin
        uop         = '0;
        uop.op      = rvopimm_pkg::OP_NONE;
        uop.rd      = dest_reg;
        uop.rs      = src_reg;
        uop.shamt   = short_imm[4:0];
        unique case (kind_e)
            rvopimm_pkg::KIND_ALU:
            begin
                uop.operand = imm_sext;
                uop.wr      = rd_ok;
                unique case (f3_e)
                    rvopimm_pkg::F3_ADD:  uop.op = rvopimm_pkg::OP_ADD;
                    rvopimm_pkg::F3_SLL:  uop.op = rvopimm_pkg::OP_SLL;
                    rvopimm_pkg::F3_SLT:  uop.op = rvopimm_pkg::OP_SLT;
                    rvopimm_pkg::F3_SLTU: uop.op = rvopimm_pkg::OP_SLTU;
                    rvopimm_pkg::F3_XOR:  uop.op = rvopimm_pkg::OP_XOR;
                    rvopimm_pkg::F3_SR:
                    begin
                        priority if (shift_variant == rvopimm_pkg::F7_SRL)
                            uop.op = rvopimm_pkg::OP_SRL;
                        else if (shift_variant == rvopimm_pkg::F7_SRA)
                            uop.op = rvopimm_pkg::OP_SRA;
                        else
                        begin
                            uop.op      = rvopimm_pkg::OP_NONE;
                            uop.illegal = 1'b1;
                            uop.wr      = 1'b0;
                        end
                    end
                    rvopimm_pkg::F3_OR:   uop.op = rvopimm_pkg::OP_OR;
                    rvopimm_pkg::F3_AND:  uop.op = rvopimm_pkg::OP_AND;
                    default:              uop.op = rvopimm_pkg::OP_NONE;
                endcase
            end
            rvopimm_pkg::KIND_LUI:
            begin
                uop.op      = rvopimm_pkg::OP_UPPER;
                uop.operand = upper_imm;
                uop.wr      = rd_ok;
            end
            rvopimm_pkg::KIND_AUIPC:
            begin
                uop.op      = rvopimm_pkg::OP_UPPER;
                uop.operand = pc_value + upper_imm;
                uop.wr      = rd_ok;
            end
            rvopimm_pkg::KIND_NOP:
            begin
                uop.op = rvopimm_pkg::OP_NONE;
            end
            default:
            begin
                uop.op = rvopimm_pkg::OP_NONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/rvopimm_queue.sv @@
`default_nettype none

module rvopimm_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  rvopimm_pkg::uop_t          push_data,
    input  wire logic                  pop,
    output rvopimm_pkg::uop_t          head,
    output rvopimm_pkg::q_status_t     status
);

    localparam int PtrW = (rvopimm_pkg::QUEUE_DEPTH > 1) ? $clog2(rvopimm_pkg::QUEUE_DEPTH) : 1;
    localparam int CntW = $clog2(rvopimm_pkg::QUEUE_DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(rvopimm_pkg::QUEUE_DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(rvopimm_pkg::QUEUE_DEPTH);

    rvopimm_pkg::uop_t  mem_reg [rvopimm_pkg::QUEUE_DEPTH];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;

    assign head         = mem_reg[rd_ptr_reg];
    assign status.full  = (count_reg == CntFull);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PtrLast) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PtrLast) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!status.full || pop))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !status.empty)
        else $error("queue pop while empty");

endmodule

`default_nettype wire

@@ rtl/core/rvopimm_back.sv @@
`default_nettype none

module rvopimm_back #(
    parameter int REG_COUNT = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              fire,
    input  rvopimm_pkg::uop_t      uop,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output logic                   out_we,
    output logic [4:0]             out_rd,
    output logic [31:0]            out_value,
    output logic                   out_illegal
);

    localparam int IdxW = $clog2(REG_COUNT);
    localparam logic [5:0] RegCountW = 6'(REG_COUNT);

    logic [31:0] rf_reg [REG_COUNT];
    logic [31:0] src_val;
    logic [31:0] res;
    logic        rs_ok;

    logic        out_valid_reg, out_valid_next;
    logic        out_we_reg;
    logic [4:0]  out_rd_reg;
    logic [31:0] out_value_reg;
    logic        out_illegal_reg;

    assign rs_ok   = (uop.rs != 5'd0) && ({1'b0, uop.rs} < RegCountW);
    assign src_val = rs_ok ? rf_reg[uop.rs[IdxW-1:0]] : 32'd0;

    always_comb
    begin
        unique case (uop.op)
            rvopimm_pkg::OP_ADD:   res = src_val + uop.operand;
            rvopimm_pkg::OP_SLL:   res = src_val << uop.shamt;
            rvopimm_pkg::OP_SLT:   res = {31'd0, $signed(src_val) < $signed(uop.operand)};
            rvopimm_pkg::OP_SLTU:  res = {31'd0, src_val < uop.operand};
            rvopimm_pkg::OP_XOR:   res = src_val ^ uop.operand;
            rvopimm_pkg::OP_SRL:   res = src_val >> uop.shamt;
            rvopimm_pkg::OP_SRA:   res = 32'($signed(src_val) >>> uop.shamt);
            rvopimm_pkg::OP_OR:    res = src_val | uop.operand;
            rvopimm_pkg::OP_AND:   res = src_val & uop.operand;
            rvopimm_pkg::OP_UPPER: res = uop.operand;
            default:               res = 32'd0;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
                rf_reg[i] <= 32'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (fire && uop.wr)
                rf_reg[uop.rd[IdxW-1:0]] <= res;
        end
    end

    // dropped writes report zeros
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_we_reg      <= uop.wr;
            out_rd_reg      <= uop.wr ? uop.rd : 5'd0;
            out_value_reg   <= uop.wr ? res : 32'd0;
            out_illegal_reg <= uop.illegal;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_we      = out_we_reg;
    assign out_rd      = out_rd_reg;
    assign out_value   = out_value_reg;
    assign out_illegal = out_illegal_reg;

    a_wb_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && uop.wr) |=> (rf_reg[$past(uop.rd[IdxW-1:0])] == out_value_reg))
        else $error("write-back value not in register file");

    a_illegal_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && uop.illegal) |=> (out_valid_reg && out_illegal_reg && !out_we_reg))
        else $error("illegal request produced a write");

endmodule

`default_nettype wire

@@ rtl/core/rv32i_op_imm_execute_core.sv @@
`default_nettype none

// RV32I OP-IMM / LUI / AUIPC execute core. Sustains one request per cycle
// while the output is not held off; an accepted request is queued, popped
// once the output is free, and its result registered at the output. The
// front end decodes funct3/funct7, sign-extends the immediate and forms the
// AUIPC sum; a two-entry queue decouples it from the back end, which reads
// rs1, runs the ALU and writes the result back (that register-file loop sets
// the one-per-cycle rate). Register zero and indexes at or above REG_COUNT
// read as zero and drop writes; a right shift with unknown funct7 raises
// illegal and writes nothing. The register file clears on reset.
module rv32i_op_imm_execute_core #(
    parameter int REG_COUNT = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // dest_reg[4:0], src_reg[9:5], op_code[12:10], shift_variant[19:13],
    // short_imm[31:20], upper_imm[63:32], pc_value[95:64]
    input  wire logic [95:0]  s_axis_tdata,
    // kind[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // write_enable[0], write_reg[5:1], write_value[37:6], zero pad[39:38]
    output logic [39:0]       m_axis_tdata,
    // illegal[0]
    output logic [0:0]        m_axis_tuser
);

    rvopimm_pkg::uop_t      dec_uop;
    rvopimm_pkg::uop_t      head_uop;
    rvopimm_pkg::q_status_t q_status;
    logic                   push;
    logic                   pop;
    logic                   out_we;
    logic [4:0]             out_rd;
    logic [31:0]            out_value;
    logic                   out_illegal;

    assign s_axis_tready = !q_status.full;
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = !q_status.empty && (!m_axis_tvalid || m_axis_tready);

    rvopimm_front #(
        .REG_COUNT(REG_COUNT)
    ) u_front (
        .kind          (s_axis_tuser),
        .dest_reg      (s_axis_tdata[4:0]),
        .src_reg       (s_axis_tdata[9:5]),
        .op_code       (s_axis_tdata[12:10]),
        .shift_variant (s_axis_tdata[19:13]),
        .short_imm     (s_axis_tdata[31:20]),
        .upper_imm     (s_axis_tdata[63:32]),
        .pc_value      (s_axis_tdata[95:64]),
        .uop           (dec_uop)
    );

    rvopimm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (dec_uop),
        .pop       (pop),
        .head      (head_uop),
        .status    (q_status)
    );

    rvopimm_back #(
        .REG_COUNT(REG_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (pop),
        .uop         (head_uop),
        .out_ready   (m_axis_tready),
        .out_valid   (m_axis_tvalid),
        .out_we      (out_we),
        .out_rd      (out_rd),
        .out_value   (out_value),
        .out_illegal (out_illegal)
    );

    assign m_axis_tdata = {2'b00, out_value, out_rd, out_we};
    assign m_axis_tuser = out_illegal;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none

module tb_top;
    import rvopimm_pkg::*;

    localparam int REG_COUNT   = 32;
    localparam int RAND_ITEMS  = 1300;
    localparam int TAIL_ITEMS  = 150;
    localparam int HOLD_AT     = 300;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_AT    = 700;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        bit        we;
        bit [4:0]  rd;
        bit [31:0] value;
        bit        illegal;
    } writeback_t;

    class writeback_scoreboard;
        bit [31:0]  regs [32];
        writeback_t pending_wb [$];
        int         errors;

        function bit [31:0] read_reg(bit [4:0] idx);
            if (idx == 0 || idx >= REG_COUNT)
                return 32'd0;
            return regs[idx];
        endfunction

        function int pending_count();
            return pending_wb.size();
        endfunction

        // predict writeback of one accepted request and update shadow regs
        function void note_request(kind_t k, bit [95:0] d);
            bit [4:0]   rd;
            bit [4:0]   rs;
            funct3_t    f3;
            bit [6:0]   f7;
            bit [31:0]  imm;
            bit [31:0]  a;
            bit [4:0]   sh;
            bit [31:0]  val;
            bit         wr;
            bit         bad;
            writeback_t e;
            rd  = d[4:0];
            rs  = d[9:5];
            f3  = funct3_t'(d[12:10]);
            f7  = d[19:13];
            imm = {{20{d[31]}}, d[31:20]};
            a   = read_reg(rs);
            sh  = imm[4:0];
            val = 32'd0;
            wr  = 1'b1;
            bad = 1'b0;
            case (k)
                KIND_ALU:
                    case (f3)
                        F3_ADD:  val = a + imm;
                        F3_SLL:  val = a << sh;
                        F3_SLT:  val = ($signed(a) < $signed(imm)) ? 32'd1 : 32'd0;
                        F3_SLTU: val = (a < imm) ? 32'd1 : 32'd0;
                        F3_XOR:  val = a ^ imm;
                        F3_SR:
                            if (f7 == F7_SRL)
                                val = a >> sh;
                            else if (f7 == F7_SRA)
                                val = $signed(a) >>> sh;
                            else
                            begin
                                bad = 1'b1;
                                wr  = 1'b0;
                            end
                        F3_OR:   val = a | imm;
                        default: val = a & imm;
                    endcase
                KIND_LUI:   val = d[63:32];
                KIND_AUIPC: val = d[95:64] + d[63:32];
                default:    wr = 1'b0;
            endcase
            if (wr && rd != 0 && rd < REG_COUNT)
            begin
                regs[rd] = val;
                e = '{1'b1, rd, val, 1'b0};
            end
            else
                e = '{1'b0, 5'd0, 32'd0, bad};
            pending_wb.push_back(e);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $realtime, msg);
        endtask

        task check_result(bit [39:0] d, bit ill);
            writeback_t e;
            if (pending_wb.size() == 0)
            begin
                report_mismatch($sformatf("writeback with nothing pending: %h", d));
                return;
            end
            e = pending_wb.pop_front();
            if (d[0] != e.we)
                report_mismatch($sformatf("write_enable %0b, want %0b", d[0], e.we));
            if (d[5:1] != e.rd)
                report_mismatch($sformatf("write_reg %0d, want %0d", d[5:1], e.rd));
            if (d[37:6] != e.value)
                report_mismatch($sformatf("write_value %h, want %h", d[37:6], e.value));
            if (ill != e.illegal)
                report_mismatch($sformatf("illegal %0b, want %0b", ill, e.illegal));
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    bit hold_out;
    bit quiet_tail;
    int cycle_count;

    writeback_scoreboard sb = new;

    rv32i_op_imm_execute_core #(
        .REG_COUNT (REG_COUNT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
        clk = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser[0]);
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_request(kind_t'(s_axis_tuser), s_axis_tdata);
    end

    // writeback side backpressure
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out      = 1'b0;
                m_axis_tready = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                m_axis_tready = 1'b1;
            end
            else
                m_axis_tready = 1'b1;
        end
    end

    task automatic send_request(input kind_t k, input bit [4:0] rd, input bit [4:0] rs,
                                input funct3_t f3, input bit [6:0] f7, input bit [11:0] imm,
                                input bit [31:0] uimm, input bit [31:0] pc);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = k;
        s_axis_tdata  = {pc, uimm, imm, f7, f3, rs, rd};
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic sender_idle(input int n);
        s_axis_tvalid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic send_random();
        int       pick;
        kind_t    k;
        funct3_t  f3;
        bit [6:0] f7;
        bit [11:0] imm;
        bit [31:0] uimm;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            k = KIND_ALU;
        else if (pick < 82)
            k = KIND_LUI;
        else if (pick < 94)
            k = KIND_AUIPC;
        else
            k = KIND_NOP;
        f3 = funct3_t'(3'($urandom_range(0, 7)));
        f7 = 7'($urandom_range(0, 127));
        if (f3 == F3_SR && $urandom_range(0, 9) < 8)
            f7 = $urandom_range(0, 1) ? F7_SRA : F7_SRL;
        case ($urandom_range(0, 3))
            0:       imm = 12'($urandom);
            1:       imm = 12'($urandom_range(0, 31));
            2:       imm = 12'hFFF - 12'($urandom_range(0, 31));
            default: imm = $urandom_range(0, 1) ? 12'h800 : 12'h7FF;
        endcase
        uimm = $urandom;
        if ($urandom_range(0, 1))
            uimm[11:0] = 12'd0;
        send_request(k, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), f3, f7, imm,
                     uimm, $urandom);
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = KIND_ALU;
        rst_n         = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(KIND_LUI,   5'd1,  5'd0,  F3_ADD,  7'd0,   12'h000, 32'hFFFF_FFFF, 32'd0);
        send_request(KIND_LUI,   5'd2,  5'd0,  F3_ADD,  7'd0,   12'h000, 32'h8000_0000, 32'd0);
        send_request(KIND_LUI,   5'd0,  5'd0,  F3_ADD,  7'd0,   12'h000, 32'hABCD_E000, 32'd0);
        send_request(KIND_AUIPC, 5'd3,  5'd0,  F3_ADD,  7'd0,   12'h000, 32'h0000_1000,
                     32'hFFFF_FFFF);
        send_request(KIND_AUIPC, 5'd31, 5'd0,  F3_ADD,  7'd0,   12'h000, 32'hFFFF_F000,
                     32'h1234_5678);
        send_request(KIND_NOP,   5'd5,  5'd1,  F3_SR,   7'd127, 12'hFFF, 32'hFFFF_FFFF,
                     32'hFFFF_FFFF);
        send_request(KIND_ALU,   5'd4,  5'd2,  F3_ADD,  7'd0,   12'h800, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd5,  5'd0,  F3_ADD,  7'd0,   12'h7FF, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd6,  5'd1,  F3_ADD,  7'd0,   12'h001, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd7,  5'd1,  F3_SLL,  7'd127, 12'h01F, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd8,  5'd2,  F3_SLT,  7'd0,   12'h000, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd9,  5'd1,  F3_SLT,  7'd0,   12'h800, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd10, 5'd5,  F3_SLTU, 7'd0,   12'hFFF, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd11, 5'd1,  F3_SLTU, 7'd0,   12'h800, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd12, 5'd2,  F3_XOR,  7'd0,   12'hFFF, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd13, 5'd2,  F3_SR,   F7_SRL, 12'h01F, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd14, 5'd2,  F3_SR,   F7_SRA, 12'h01F, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd15, 5'd1,  F3_SR,   F7_SRA, 12'h000, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd16, 5'd2,  F3_SR,   7'd1,   12'h004, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd17, 5'd2,  F3_SR,   7'd127, 12'h004, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd18, 5'd2,  F3_OR,   7'd0,   12'h800, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd19, 5'd1,  F3_AND,  7'd0,   12'h7FF, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd0,  5'd1,  F3_ADD,  7'd0,   12'h005, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd20, 5'd31, F3_ADD,  7'd0,   12'hFFF, 32'd0, 32'd0);
        send_request(KIND_ALU,   5'd21, 5'd0,  F3_SR,   F7_SRL, 12'h005, 32'd0, 32'd0);

        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i == HOLD_AT)
                hold_out = 1'b1;
            if (i == DRAIN_AT)
            begin
                s_axis_tvalid = 1'b0;
                while (sb.pending_count() != 0)
                    @(negedge clk);
            end
            if (i == RAND_ITEMS - TAIL_ITEMS)
                quiet_tail = 1'b1;
            // keep offering back to back while the writeback side is held off
            if (!quiet_tail && !(i >= HOLD_AT && i < HOLD_AT + 30)
                && $urandom_range(0, 5) == 0)
                sender_idle($urandom_range(1, 12));
            send_random();
        end
        s_axis_tvalid = 1'b0;

        while (sb.pending_count() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

@@ files.f @@
rtl/core/rvopimm_pkg.sv
rtl/core/rvopimm_front.sv
rtl/core/rvopimm_queue.sv
rtl/core/rvopimm_back.sv
rtl/core/rv32i_op_imm_execute_core.sv
tb/tb_top.sv
